// ===== rtl/assert_macros.svh =====
// Assertion macros of the record frame parser RTL.
// Expands to concurrent assertions in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RFP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define RFP_ASSERT(lbl, clk, rst_n, prop)
`define RFP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/rfp_pkg.sv =====
// Types, constants and helpers of the record frame receive parser.
// No dependencies; used by rfp_step, the top level and the testbench checker and top.
package rfp_pkg;

    localparam int MAX_RECORDS = 255;
    localparam logic [7:0] COUNT_CAP = 8'((MAX_RECORDS < 255) ? MAX_RECORDS : 255);

    localparam logic [7:0] BYTE_STX   = 8'h02;
    localparam logic [7:0] BYTE_ETX   = 8'h03;
    localparam logic [7:0] BYTE_ACK   = 8'h06;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] TYPE_GET   = 8'h80;

    localparam logic [2:0] CLS_GET    = 3'd0;
    localparam logic [2:0] CLS_SET1   = 3'd1;
    localparam logic [2:0] CLS_SET8   = 3'd4;
    localparam logic [2:0] CLS_VARLEN = 3'd5;

    typedef enum logic [3:0] {
        PS_IDLE = 4'd0,
        PS_POST = 4'd1,
        PS_LEN1 = 4'd2,
        PS_LEN2 = 4'd3,
        PS_LEN3 = 4'd4,
        PS_ID1  = 4'd5,
        PS_ID2  = 4'd6,
        PS_DATA = 4'd7,
        PS_CR   = 4'd8,
        PS_ETX  = 4'd9
    } t_pstate;

    typedef enum logic [1:0] {
        STAT_BUSY  = 2'd0,
        STAT_ACK   = 2'd1,
        STAT_ERROR = 2'd2,
        STAT_DONE  = 2'd3
    } t_status;

    typedef struct packed {
        t_pstate     st;
        logic [7:0]  xr;
        logic [7:0]  rtype;
        logic [23:0] rem;
        logic [15:0] id;
        logic [6:0]  addr;
        logic [7:0]  gcnt;
        logic [7:0]  scnt;
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [6:0]  addr;
        logic [15:0] id;
        logic        is_set;
        logic        pvalid;
        logic [7:0]  pbyte;
        logic        rdone;
        logic [7:0]  gcnt;
        logic [7:0]  scnt;
    } t_result;

    localparam t_state STATE_RESET = '{
        st: PS_IDLE, xr: 8'h00, rtype: 8'h00, rem: 24'h0, id: 16'h0,
        addr: 7'h0, gcnt: 8'h00, scnt: 8'h00
    };

    function automatic logic [7:0] bump(input logic [7:0] c);
        return (c < COUNT_CAP) ? c + 8'd1 : c;
    endfunction

    // Fixed data length of SET classes one to four: 1, 2, 4, 8 bytes.
    function automatic logic [23:0] fixed_len(input logic [2:0] cls);
        logic [1:0] sh;
        sh = 2'(cls - CLS_SET1);
        return 24'd1 << sh;
    endfunction

endpackage

// ===== rtl/rfp_in_reg.sv =====
// Input register of the record frame parser: holds one received byte.
// Depends on nothing but the clock and reset.
module rfp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_advance,
    output logic       o_hold_valid,
    output logic [7:0] o_hold_byte
);
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;

    assign o_in_ready   = !r_valid || i_advance;
    assign o_hold_valid = r_valid;
    assign o_hold_byte  = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_rx_byte;
        end
    end
endmodule

// ===== rtl/rfp_step.sv =====
// Per-byte parse step: next parser state and the result for one byte.
// Depends on rfp_pkg.
module rfp_step (
    input  rfp_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    output rfp_pkg::t_state  o_state,
    output rfp_pkg::t_result o_result
);
    import rfp_pkg::*;

    t_state     n;
    t_status    status;
    logic       pvalid;
    logic [7:0] pbyte;
    logic       rdone;
    logic [2:0] cls;
    logic [2:0] ncls;

    assign cls = i_byte[2:0];

    always_comb begin
        n      = i_state;
        status = STAT_BUSY;
        pvalid = 1'b0;
        pbyte  = 8'h00;
        rdone  = 1'b0;
        n.xr   = i_state.xr ^ i_byte;
        case (i_state.st)
            PS_POST: begin
                if (i_byte[7]) begin
                    n.rtype = i_byte;
                    if (cls == CLS_GET) begin
                        n.gcnt = bump(i_state.gcnt);
                        n.rem  = 24'h0;
                        n.st   = PS_ID1;
                    end else if (cls <= CLS_SET8) begin
                        n.scnt = bump(i_state.scnt);
                        n.rem  = fixed_len(cls);
                        n.st   = PS_ID1;
                    end else if (cls == CLS_VARLEN) begin
                        n.scnt = bump(i_state.scnt);
                        n.rem  = 24'h0;
                        n.st   = PS_LEN1;
                    end
                end else if (i_state.gcnt != 8'h00 || i_state.scnt != 8'h00) begin
                    n.xr = i_state.xr;
                    if (i_state.xr[6:0] == i_byte[6:0]) begin
                        n.st = PS_ETX;
                    end else begin
                        status = STAT_ERROR;
                    end
                end else begin
                    n.addr = i_byte[6:0];
                end
            end
            PS_LEN1: begin
                n.rem = {16'h0, i_byte};
                n.st  = PS_LEN2;
            end
            PS_LEN2: begin
                n.rem = i_state.rem | {8'h0, i_byte, 8'h0};
                n.st  = PS_LEN3;
            end
            PS_LEN3: begin
                n.rem = i_state.rem | {i_byte, 16'h0};
                n.st  = PS_ID1;
            end
            PS_ID1: begin
                n.id = {8'h0, i_byte};
                n.st = PS_ID2;
            end
            PS_ID2: begin
                n.id = i_state.id | {i_byte, 8'h0};
                n.st = (i_state.rtype == TYPE_GET) ? PS_CR : PS_DATA;
            end
            PS_DATA: begin
                if (i_state.rem != 24'h0) begin
                    n.rem  = i_state.rem - 24'd1;
                    pvalid = 1'b1;
                    pbyte  = i_byte;
                    if (i_state.rem == 24'd1) begin
                        n.st = PS_CR;
                    end
                end else begin
                    status = STAT_ERROR;
                end
            end
            PS_CR: begin
                if (i_byte == BYTE_CR) begin
                    rdone = 1'b1;
                    n.st  = PS_POST;
                end else begin
                    status = STAT_ERROR;
                end
            end
            PS_ETX: begin
                status = (i_byte == BYTE_ETX) ? STAT_DONE : STAT_ERROR;
            end
            default: begin
                if (i_byte == BYTE_STX) begin
                    n    = STATE_RESET;
                    n.xr = BYTE_STX;
                    n.st = PS_POST;
                end else begin
                    n.st = PS_IDLE;
                    if (i_byte == BYTE_ACK) begin
                        status = STAT_ACK;
                    end
                end
            end
        endcase
        if (status == STAT_ERROR || status == STAT_DONE) begin
            n.st = PS_IDLE;
        end
    end

    assign ncls = n.rtype[2:0];

    always_comb begin
        o_state         = n;
        o_result.status = status;
        o_result.addr   = n.addr;
        o_result.id     = n.id;
        o_result.is_set = (ncls >= CLS_SET1) && (ncls <= CLS_VARLEN);
        o_result.pvalid = pvalid;
        o_result.pbyte  = pbyte;
        o_result.rdone  = rdone;
        o_result.gcnt   = n.gcnt;
        o_result.scnt   = n.scnt;
    end
endmodule

// ===== rtl/record_frame_receive_parser_unit.sv =====
// Channel  | Signals                                   | Direction
// request  | i_in_valid, o_in_ready, i_rx_byte         | byte in
// result   | o_out_valid, i_out_ready, o_status ...    | one result per byte out
//
// One byte per cycle unless results stall; registers: input, then result.
// The parse state updates as a held byte moves into the result register.
// A stalled result holds the result register and then the input register.
// Reset clears the parse state, the counts and both valid flags.
// Top level of the record frame receive parser; uses rfp_pkg, rfp_in_reg, rfp_step
// and the assertion macros in assert_macros.svh.
`include "assert_macros.svh"
module record_frame_receive_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_dest_address,
    output logic [15:0] o_record_id,
    output logic        o_record_is_set,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic        o_record_done,
    output logic [7:0]  o_get_records,
    output logic [7:0]  o_set_records
);
    import rfp_pkg::*;

    logic       hold_valid;
    logic [7:0] hold_byte;
    logic       advance;
    t_state     r_state;
    t_state     n_state;
    t_result    n_res;
    t_result    r_res;
    logic       r_out_valid;
    logic       n_out_valid;

    assign advance = hold_valid && (!r_out_valid || i_out_ready);

    rfp_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_advance    (advance),
        .o_hold_valid (hold_valid),
        .o_hold_byte  (hold_byte)
    );

    rfp_step u_step (
        .i_state  (r_state),
        .i_byte   (hold_byte),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_res.status;
    assign o_dest_address  = r_res.addr;
    assign o_record_id     = r_res.id;
    assign o_record_is_set = r_res.is_set;
    assign o_payload_valid = r_res.pvalid;
    assign o_payload_byte  = r_res.pbyte;
    assign o_record_done   = r_res.rdone;
    assign o_get_records   = r_res.gcnt;
    assign o_set_records   = r_res.scnt;

    `RFP_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !r_out_valid && !hold_valid)
    `RFP_ASSERT(a_payload_busy, i_clk, i_rst_n, r_out_valid && r_res.pvalid |-> r_res.status == STAT_BUSY && !r_res.rdone)
    `RFP_ASSERT(a_done_busy, i_clk, i_rst_n, r_out_valid && r_res.rdone |-> r_res.status == STAT_BUSY)
    `RFP_ASSERT(a_stall_holds, i_clk, i_rst_n, hold_valid && !advance |=> hold_valid && $stable(hold_byte) && $stable(r_state))
    `RFP_ASSERT(a_count_cap, i_clk, i_rst_n, r_state.gcnt <= COUNT_CAP && r_state.scnt <= COUNT_CAP)
endmodule

// ===== tb/record_frame_receive_parser_checker.sv =====
// Checker for the record frame receive parser: watches both channels, predicts each result.
// Depends on rfp_pkg for the status and parse state codes and the record count cap.
`timescale 1ns / 1ps
module record_frame_receive_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [6:0]  i_dest_address,
    input  logic [15:0] i_record_id,
    input  logic        i_record_is_set,
    input  logic        i_payload_valid,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_record_done,
    input  logic [7:0]  i_get_records,
    input  logic [7:0]  i_set_records,
    output int          o_fail_count,
    output int          o_outstanding
);
    import rfp_pkg::*;

    localparam logic [2:0] CLS_SET2 = 3'd2;
    localparam logic [2:0] CLS_SET4 = 3'd3;
    localparam int REPORT_LIMIT = 10;

    t_pstate     prs_state;
    logic [7:0]  prs_xor;
    logic [7:0]  prs_type;
    logic [23:0] prs_remaining;
    logic [15:0] prs_id;
    logic [6:0]  prs_addr;
    logic [7:0]  prs_gets;
    logic [7:0]  prs_sets;

    t_result expected_results[$];
    int      fail_count = 0;
    int      result_no = 0;

    assign o_fail_count = fail_count;

    task clear_parser();
        prs_state     = PS_IDLE;
        prs_xor       = 8'h00;
        prs_type      = 8'h00;
        prs_remaining = 24'h0;
        prs_id        = 16'h0;
        prs_addr      = 7'h0;
        prs_gets      = 8'h00;
        prs_sets      = 8'h00;
    endtask

    task advance_parser(input logic [7:0] rx, output t_result res);
        logic [2:0] cls;
        t_status    st;
        logic       pv;
        logic [7:0] pb;
        logic       rd;
        st = STAT_BUSY;
        pv = 1'b0;
        pb = 8'h00;
        rd = 1'b0;
        prs_xor = prs_xor ^ rx;
        case (prs_state)
            PS_POST: begin
                if (rx[7]) begin
                    prs_type = rx;
                    cls = rx[2:0];
                    if (cls == CLS_GET) begin
                        if (prs_gets < COUNT_CAP) prs_gets = prs_gets + 8'd1;
                        prs_remaining = 24'h0;
                        prs_state = PS_ID1;
                    end else if (cls <= CLS_SET8) begin
                        if (prs_sets < COUNT_CAP) prs_sets = prs_sets + 8'd1;
                        case (cls)
                            CLS_SET1: prs_remaining = 24'd1;
                            CLS_SET2: prs_remaining = 24'd2;
                            CLS_SET4: prs_remaining = 24'd4;
                            default:  prs_remaining = 24'd8;
                        endcase
                        prs_state = PS_ID1;
                    end else if (cls == CLS_VARLEN) begin
                        if (prs_sets < COUNT_CAP) prs_sets = prs_sets + 8'd1;
                        prs_remaining = 24'h0;
                        prs_state = PS_LEN1;
                    end
                end else if (prs_gets != 8'h00 || prs_sets != 8'h00) begin
                    prs_xor = prs_xor ^ rx;
                    if ({1'b0, prs_xor[6:0]} == rx) prs_state = PS_ETX;
                    else st = STAT_ERROR;
                end else begin
                    prs_addr = rx[6:0];
                end
            end
            PS_LEN1: begin
                prs_remaining = {16'h0, rx};
                prs_state = PS_LEN2;
            end
            PS_LEN2: begin
                prs_remaining = prs_remaining | {8'h0, rx, 8'h0};
                prs_state = PS_LEN3;
            end
            PS_LEN3: begin
                prs_remaining = prs_remaining | {rx, 16'h0};
                prs_state = PS_ID1;
            end
            PS_ID1: begin
                prs_id = {8'h0, rx};
                prs_state = PS_ID2;
            end
            PS_ID2: begin
                prs_id = prs_id | {rx, 8'h0};
                prs_state = (prs_type == TYPE_GET) ? PS_CR : PS_DATA;
            end
            PS_DATA: begin
                if (prs_remaining != 24'h0) begin
                    prs_remaining = prs_remaining - 24'd1;
                    pv = 1'b1;
                    pb = rx;
                    if (prs_remaining == 24'h0) prs_state = PS_CR;
                end else begin
                    st = STAT_ERROR;
                end
            end
            PS_CR: begin
                if (rx == BYTE_CR) begin
                    rd = 1'b1;
                    prs_state = PS_POST;
                end else begin
                    st = STAT_ERROR;
                end
            end
            PS_ETX: begin
                st = (rx == BYTE_ETX) ? STAT_DONE : STAT_ERROR;
            end
            default: begin
                if (rx == BYTE_STX) begin
                    prs_xor       = BYTE_STX;
                    prs_type      = 8'h00;
                    prs_remaining = 24'h0;
                    prs_id        = 16'h0;
                    prs_addr      = 7'h0;
                    prs_gets      = 8'h00;
                    prs_sets      = 8'h00;
                    prs_state     = PS_POST;
                end else begin
                    if (rx == BYTE_ACK) st = STAT_ACK;
                    prs_state = PS_IDLE;
                end
            end
        endcase
        if (st == STAT_ERROR || st == STAT_DONE) prs_state = PS_IDLE;

        cls = prs_type[2:0];
        res.status = st;
        res.addr   = prs_addr;
        res.id     = prs_id;
        res.is_set = (cls >= CLS_SET1 && cls <= CLS_VARLEN);
        res.pvalid = pv;
        res.pbyte  = pb;
        res.rdone  = rd;
        res.gcnt   = prs_gets;
        res.scnt   = prs_sets;
    endtask

    task check_field(input string name, input logic [15:0] exp_v, input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            fail_count = fail_count + 1;
            if (fail_count <= REPORT_LIMIT)
                $display("result %0d %s mismatch: expected %0h actual %0h",
                         result_no, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result exp_res;
        t_result new_res;
        if (!i_rst_n) begin
            clear_parser();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result %0d arrived with nothing expected", result_no);
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("status", 16'(exp_res.status), 16'(i_status));
                    check_field("dest_address", 16'(exp_res.addr), 16'(i_dest_address));
                    check_field("record_id", exp_res.id, i_record_id);
                    check_field("record_is_set", 16'(exp_res.is_set), 16'(i_record_is_set));
                    check_field("payload_valid", 16'(exp_res.pvalid), 16'(i_payload_valid));
                    check_field("payload_byte", 16'(exp_res.pbyte), 16'(i_payload_byte));
                    check_field("record_done", 16'(exp_res.rdone), 16'(i_record_done));
                    check_field("get_records", 16'(exp_res.gcnt), 16'(i_get_records));
                    check_field("set_records", 16'(exp_res.scnt), 16'(i_set_records));
                end
                result_no = result_no + 1;
            end
            if (i_in_valid && i_in_ready) begin
                advance_parser(i_rx_byte, new_res);
                expected_results.push_back(new_res);
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

// ===== tb/tb_record_frame_receive_parser_unit.sv =====
// Testbench top for record_frame_receive_parser_unit: builds framed byte streams and drives them.
// Depends on rfp_pkg, the block and record_frame_receive_parser_checker.
`timescale 1ns / 1ps
module tb_record_frame_receive_parser_unit;
    import rfp_pkg::*;

    localparam int RUN_LIMIT = 20000;
    localparam int LONG_HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [6:0]  o_dest_address;
    logic [15:0] o_record_id;
    logic        o_record_is_set;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic        o_record_done;
    logic [7:0]  o_get_records;
    logic [7:0]  o_set_records;

    int          fail_count;
    int          outstanding;

    logic [7:0]  tx_bytes[$];
    logic [7:0]  frame_sum = 8'h00;
    int          queued_total = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          long_stall_go = 1'b0;
    logic        rx_hold = 1'b0;
    int          cycle_count = 0;

    record_frame_receive_parser_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_dest_address  (o_dest_address),
        .o_record_id     (o_record_id),
        .o_record_is_set (o_record_is_set),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_record_done   (o_record_done),
        .o_get_records   (o_get_records),
        .o_set_records   (o_set_records)
    );

    record_frame_receive_parser_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_status        (o_status),
        .i_dest_address  (o_dest_address),
        .i_record_id     (o_record_id),
        .i_record_is_set (o_record_is_set),
        .i_payload_valid (o_payload_valid),
        .i_payload_byte  (o_payload_byte),
        .i_record_done   (o_record_done),
        .i_get_records   (o_get_records),
        .i_set_records   (o_set_records),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_rx_byte  <= tx_bytes.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // hold off the result side long enough for the block to fill and stall its input
    initial begin
        wait (long_stall_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
        end
        $display("tb_record_frame_receive_parser_unit failed");
        $finish;
    end

    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        frame_sum = frame_sum ^ b;
        queued_total = queued_total + 1;
    endtask

    task automatic queue_record(input bit sound);
        int          flaw;
        int          nbytes;
        logic [2:0]  cls;
        logic [7:0]  rtype;
        logic [7:0]  last;
        logic [23:0] vlen;
        flaw = sound ? 0 : $urandom_range(1, 3);
        cls = 3'($urandom_range(0, 5));
        if (flaw == 1) cls = CLS_GET;
        if (flaw == 2) cls = CLS_VARLEN;
        if ($urandom_range(9) == 0)
            queue_byte({1'b1, 4'($urandom), 3'($urandom_range(6, 7))});
        rtype = {1'b1, 4'($urandom), cls};
        if (cls == CLS_GET) rtype = TYPE_GET;
        if (flaw == 1) rtype[3 + $urandom_range(0, 3)] = 1'b1;
        queue_byte(rtype);
        nbytes = (cls == CLS_GET) ? 0 : (cls == CLS_VARLEN) ? 0 : (1 << (cls - CLS_SET1));
        if (cls == CLS_VARLEN) begin
            if (flaw == 2) vlen = 24'h0;
            else if ($urandom_range(49) == 0) vlen = 24'h000100 + 24'($urandom_range(0, 8));
            else vlen = 24'($urandom_range(1, 6));
            queue_byte(vlen[7:0]);
            queue_byte(vlen[15:8]);
            queue_byte(vlen[23:16]);
            nbytes = int'(vlen);
        end
        queue_byte(8'($urandom));
        queue_byte(8'($urandom));
        if (flaw == 0 || flaw == 3) repeat (nbytes) queue_byte(8'($urandom));
        last = BYTE_CR;
        if (flaw == 3) begin
            last = 8'($urandom);
            if (last == BYTE_CR) last = ~BYTE_CR;
        end
        queue_byte(last);
    endtask

    task automatic queue_frame();
        int         fault;
        int         nrec;
        int         bad_rec;
        logic [7:0] sum;
        logic [7:0] tail;
        fault = ($urandom_range(99) < 75) ? 0 : $urandom_range(1, 4);
        nrec = $urandom_range(1, 4);
        bad_rec = (fault == 1) ? $urandom_range(0, nrec - 1) : -1;
        frame_sum = 8'h00;
        queue_byte(BYTE_STX);
        repeat ($urandom_range(0, 2)) queue_byte({1'b0, 7'($urandom)});
        for (int r = 0; r < nrec; r++) queue_record(r != bad_rec);
        if (fault != 4) begin
            sum = {1'b0, frame_sum[6:0]};
            if (fault == 2) sum[$urandom_range(0, 6)] ^= 1'b1;
            queue_byte(sum);
            tail = BYTE_ETX;
            if (fault == 3) begin
                tail = 8'($urandom);
                if (tail == BYTE_ETX) tail = ~BYTE_ETX;
            end
            queue_byte(tail);
        end
    endtask

    task automatic queue_gap();
        int r;
        r = $urandom_range(99);
        if (r < 10) queue_byte(BYTE_ACK);
        else if (r < 25) repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
    endtask

    task automatic queue_random(input int target);
        int start;
        start = queued_total;
        while (queued_total - start < target) begin
            queue_gap();
            queue_frame();
        end
    endtask

    task automatic wait_quiet();
        while (tx_bytes.size() != 0 || i_in_valid || outstanding != 0) @(negedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        wait_quiet();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        wait (i_rst_n);
        @(negedge i_clk);

        queue_byte(BYTE_ACK);
        queue_byte(8'hff);
        frame_sum = 8'h00;
        queue_byte(BYTE_STX);
        queue_byte(8'h00);
        queue_byte(8'h7f);
        queue_byte(TYPE_GET);
        queue_byte(8'hff);
        queue_byte(8'hff);
        queue_byte(BYTE_CR);
        queue_byte({5'b10001, CLS_VARLEN});
        queue_byte(8'h02);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'hff);
        queue_byte(8'h00);
        queue_byte(BYTE_CR);
        queue_byte(8'hfe);
        queue_byte({1'b0, frame_sum[6:0]});
        queue_byte(BYTE_ETX);
        wait_quiet();

        queue_random(120);

        wait_quiet();
        long_stall_go = 1'b1;
        queue_random(50);

        set_idling(72, 0);
        queue_random(120);
        set_idling(0, 72);
        queue_random(120);
        set_idling(29, 29);
        queue_random(120);

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_record_frame_receive_parser_unit passed");
        end else begin
            $display("tb_record_frame_receive_parser_unit failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rfp_pkg.sv
rtl/rfp_in_reg.sv
rtl/rfp_step.sv
rtl/record_frame_receive_parser_unit.sv
tb/record_frame_receive_parser_checker.sv
tb/tb_record_frame_receive_parser_unit.sv
